/* design/lrupr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrupr_pkg
// Shared constants and types for the LRU page replacement block.
// ----------------------------------------------------------------------------
package lrupr_pkg;

    localparam int MAX_FRAMES = 32;
    localparam int PAGE_BITS  = 16;
    localparam int CFG_W      = 6;
    localparam int FAULT_W    = 32;

    localparam logic [CFG_W-1:0] FRAME_COUNT_RESET = 6'd4;

    // per-request command broadcast to every cell of the stack
    typedef struct packed {
        logic load;   // request accepted this cycle
        logic hit;    // page found in the stack
        logic evict;  // miss with the stack full: drop the oldest entry
    } lrupr_cmd_t;

endpackage : lrupr_pkg
`default_nettype wire

/* design/lru_page_replacement.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lru_page_replacement
// Fully associative LRU page store built as a row of stack cells, with
// occupancy, saturating fault counter and a registered result stage.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  s_       | in        | tdata: page_number; tlast: end_of_run
//  m_       | out       | tdata: evicted_page, fault_total; tuser: hit, evicted_valid
//  cfg_     | in        | data: frame_count
//
//  One request per cycle unless m_tready holds back a result; the result appears the cycle after acceptance.
//  The limit is the match carry rippling through the cell row to the hit flag.
//  Reset empties the stack, clears the fault counter and sets frame_count to 4.
//  While a result waits on m_tready, s_tready is low.
// ----------------------------------------------------------------------------
module lru_page_replacement #(
    parameter  int MaxFrames = lrupr_pkg::MAX_FRAMES,
    parameter  int PageBits  = lrupr_pkg::PAGE_BITS,
    localparam int SDataW    = ((PageBits + 7) / 8) * 8,
    localparam int MDataW    = ((PageBits + lrupr_pkg::FAULT_W + 7) / 8) * 8
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_tvalid,
    output logic                         s_tready,
    input  wire  [SDataW-1:0]            s_tdata,   // [PageBits-1:0] page_number
    input  wire                          s_tlast,   // end_of_run
    output logic                         m_tvalid,
    input  wire                          m_tready,
    output logic [MDataW-1:0]            m_tdata,   // evicted_page, then fault_total
    output logic [1:0]                   m_tuser,   // [0] hit, [1] evicted_valid
    input  wire                          cfg_valid,
    output logic                         cfg_ready,
    input  wire  [lrupr_pkg::CFG_W-1:0]  cfg_data   // frame_count
);
    import lrupr_pkg::*;

    localparam int OccW = $clog2(MaxFrames + 1);
    localparam int CmpW = (OccW > CFG_W) ? OccW : CFG_W;
    localparam logic [CmpW-1:0] CAP_MAX = CmpW'(MaxFrames);

    logic [CFG_W-1:0]    frame_count_reg;
    logic [OccW-1:0]     occupancy_reg;
    logic [OccW-1:0]     occupancy_next;
    logic [FAULT_W-1:0]  fault_reg;
    logic [FAULT_W-1:0]  fault_next;
    logic [FAULT_W-1:0]  fault_inc;

    logic                out_valid_reg;
    logic                out_hit_reg;
    logic                out_ev_valid_reg;
    logic [PageBits-1:0] out_ev_page_reg;
    logic [FAULT_W-1:0]  out_fault_reg;

    logic [PageBits-1:0] page_in;
    logic [PageBits-1:0] cell_page [MaxFrames];
    logic [MaxFrames:0]  match_c;
    logic [CmpW-1:0]     fc_ext;
    logic [CmpW-1:0]     cap;
    logic                full;
    lrupr_cmd_t          cmd;

    assign page_in   = s_tdata[PageBits-1:0];
    assign s_tready  = !out_valid_reg || m_tready;
    assign cfg_ready = 1'b1;

    assign fc_ext = CmpW'(frame_count_reg);
    always_comb begin
        if (fc_ext == '0) begin
            cap = CmpW'(1);
        end else if (fc_ext > CAP_MAX) begin
            cap = CAP_MAX;
        end else begin
            cap = fc_ext;
        end
    end
    assign full = CmpW'(occupancy_reg) >= cap;

    assign match_c[0] = 1'b0;
    assign cmd = '{
        load:  s_tvalid && s_tready,
        hit:   match_c[MaxFrames],
        evict: !match_c[MaxFrames] && full
    };

    for (genvar i = 0; i < MaxFrames; i++) begin : g_cell
        logic [PageBits-1:0] upper;
        if (i == MaxFrames - 1) begin : g_last
            assign upper = '0;
        end else begin : g_mid
            assign upper = cell_page[i+1];
        end
        lrupr_cell #(
            .Index    (i),
            .PageBits (PageBits),
            .OccW     (OccW)
        ) u_cell (
            .aclk      (aclk),
            .cmd       (cmd),
            .occ       (occupancy_reg),
            .page_in   (page_in),
            .next_page (upper),
            .match_in  (match_c[i]),
            .match_out (match_c[i+1]),
            .page_out  (cell_page[i])
        );
    end

    assign fault_inc = (!cmd.hit && (fault_reg != '1)) ? fault_reg + FAULT_W'(1) : fault_reg;

    always_comb begin
        occupancy_next = occupancy_reg;
        fault_next     = fault_reg;
        if (cmd.load) begin
            if (s_tlast) begin
                occupancy_next = '0;
                fault_next     = '0;
            end else begin
                fault_next = fault_inc;
                if (!cmd.hit && !full) begin
                    occupancy_next = occupancy_reg + OccW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_count_reg <= FRAME_COUNT_RESET;
            occupancy_reg   <= '0;
            fault_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                frame_count_reg <= cfg_data;
            end
            occupancy_reg <= occupancy_next;
            fault_reg     <= fault_next;
            if (cmd.load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            out_hit_reg      <= cmd.hit;
            out_ev_valid_reg <= cmd.evict;
            out_ev_page_reg  <= cmd.evict ? cell_page[0] : '0;
            out_fault_reg    <= fault_inc;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = {out_ev_valid_reg, out_hit_reg};
    assign m_tdata  = MDataW'({out_fault_reg, out_ev_page_reg});

    // stack never grows past the number of cells
    a_occ_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        CmpW'(occupancy_reg) <= CAP_MAX)
        else $error("occupancy beyond stack depth");

    // a hit never reports an eviction
    a_hit_no_evict : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("hit and eviction in one result");

    // end of run empties the store and counter
    a_run_clear : assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load && s_tlast) |=> (occupancy_reg == '0) && (fault_reg == '0))
        else $error("run end did not clear state");

    // a hit leaves occupancy and fault count unchanged
    a_hit_stable : assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load && cmd.hit && !s_tlast) |=> $stable(occupancy_reg) && $stable(fault_reg))
        else $error("hit changed occupancy or fault count");

endmodule : lru_page_replacement
`default_nettype wire

/* design/lrupr_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrupr_cell
// One entry of the recency stack: compares against the incoming page, passes
// the match carry upward and takes its upper neighbour's page on a shift.
// ----------------------------------------------------------------------------
module lrupr_cell #(
    parameter int Index    = 0,
    parameter int PageBits = 16,
    parameter int OccW     = 6
) (
    input  wire                          aclk,
    input  wire  lrupr_pkg::lrupr_cmd_t  cmd,
    input  wire  [OccW-1:0]              occ,
    input  wire  [PageBits-1:0]          page_in,
    input  wire  [PageBits-1:0]          next_page,
    input  wire                          match_in,
    output logic                         match_out,
    output logic [PageBits-1:0]          page_out
);
    import lrupr_pkg::*;

    localparam logic [OccW-1:0] IDX     = OccW'(Index);
    localparam logic [OccW-1:0] IDX_TOP = OccW'(Index + 1);

    logic [PageBits-1:0] page_reg;
    logic [PageBits-1:0] page_next;
    logic                in_use;
    logic                is_top;
    logic                is_app;
    logic                shift;

    assign in_use    = IDX < occ;
    assign is_top    = occ == IDX_TOP;
    assign is_app    = occ == IDX;
    assign match_out = match_in | (in_use && (page_reg == page_in));
    // on a hit only entries at or above the match move; an eviction moves all
    assign shift     = cmd.hit ? match_out : cmd.evict;
    assign page_out  = page_reg;

    always_comb begin
        page_next = page_reg;
        if (cmd.load) begin
            if ((cmd.hit || cmd.evict) && is_top) begin
                page_next = page_in;
            end else if (!cmd.hit && !cmd.evict && is_app) begin
                page_next = page_in;
            end else if (shift && in_use && !is_top) begin
                page_next = next_page;
            end
        end
    end

    always_ff @(posedge aclk) begin
        page_reg <= page_next;
    end

endmodule : lrupr_cell
`default_nettype wire

/* sim/tb_lru_page_replacement.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_page_replacement
// Self-checking bench for the LRU page store: a queued stream of page
// references and frame-count writes is driven with random gaps, every
// result is checked against a behavioural LRU stack kept in the bench.
// ----------------------------------------------------------------------------
module tb_lru_page_replacement;

    import lrupr_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int ITEM_TARGET  = 750;
    localparam int CFG_SETTLE   = 4;
    localparam int GAP_PCT      = 36;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AT      = 150;
    localparam int BURST_FROM   = 400;
    localparam int BURST_TO     = 520;
    localparam int MAX_REPORTS  = 10;

    typedef enum logic {REQ_PAGE, REQ_CFG} req_kind_t;

    typedef struct {
        req_kind_t            kind;
        logic [PAGE_BITS-1:0] page;
        logic                 last;
        logic [CFG_W-1:0]     frames;
    } stim_req_t;

    typedef struct {
        logic                 hit;
        logic                 ev_valid;
        logic [PAGE_BITS-1:0] ev_page;
        logic [FAULT_W-1:0]   faults;
    } lru_result_t;

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [PAGE_BITS-1:0]          s_tdata   = '0;   // [15:0] page_number
    logic                          s_tlast   = 1'b0; // end_of_run
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [PAGE_BITS+FAULT_W-1:0]  m_tdata;          // [15:0] evicted_page, [47:16] fault_total
    logic [1:0]                    m_tuser;          // [0] hit, [1] evicted_valid
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [CFG_W-1:0]              cfg_data  = '0;

    stim_req_t   pending_reqs[$];
    lru_result_t expected_results[$];

    int unsigned pages_sent   = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches   = 0;
    int unsigned cycle_count  = 0;
    int unsigned stim_items   = 0;

    // bench copy of the page store
    logic [PAGE_BITS-1:0] lru_stack [MAX_FRAMES];
    int unsigned          lru_occ    = 0;
    logic [FAULT_W-1:0]   lru_faults = '0;
    logic [CFG_W-1:0]     lru_frames = FRAME_COUNT_RESET;

    lru_page_replacement dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // LRU prediction
    // ------------------------------------------------------------------
    function automatic int unsigned frames_in_use(input logic [CFG_W-1:0] f);
        if (f == 0) return 1;
        if (f > MAX_FRAMES) return MAX_FRAMES;
        return f;
    endfunction

    function automatic lru_result_t lru_reference(input logic [PAGE_BITS-1:0] page,
                                                  input logic last);
        lru_result_t r;
        logic        found;
        int unsigned pos;
        found = 1'b0;
        pos   = 0;
        r.hit      = 1'b0;
        r.ev_valid = 1'b0;
        r.ev_page  = '0;
        for (int unsigned i = 0; i < lru_occ; i++) begin
            if (!found && lru_stack[i] == page) begin
                found = 1'b1;
                pos   = i;
            end
        end
        if (found) begin
            r.hit = 1'b1;
            for (int unsigned i = pos; i + 1 < lru_occ; i++) lru_stack[i] = lru_stack[i+1];
            lru_stack[lru_occ-1] = page;
        end else begin
            if (lru_faults != '1) lru_faults = lru_faults + 1'b1;
            if (lru_occ < frames_in_use(lru_frames)) begin
                lru_stack[lru_occ] = page;
                lru_occ++;
            end else begin
                // occupancy never shrinks after the frame count is lowered
                r.ev_valid = 1'b1;
                r.ev_page  = lru_stack[0];
                for (int unsigned i = 0; i + 1 < lru_occ; i++) lru_stack[i] = lru_stack[i+1];
                lru_stack[lru_occ-1] = page;
            end
        end
        r.faults = lru_faults;
        if (last) begin
            lru_occ    = 0;
            lru_faults = '0;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : drive_requests
        logic                 nxt_valid;
        logic [PAGE_BITS-1:0] nxt_page;
        logic                 nxt_last;
        logic                 nxt_cfg_valid;
        logic [CFG_W-1:0]     nxt_cfg_data;
        logic                 burst;
        int unsigned          quiet;
        stim_req_t            req;
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            cfg_valid <= 1'b0;
            quiet = 0;
        end else begin
            nxt_valid     = s_tvalid;
            nxt_page      = s_tdata;
            nxt_last      = s_tlast;
            nxt_cfg_valid = cfg_valid;
            nxt_cfg_data  = cfg_data;
            burst = (pages_sent >= BURST_FROM) && (pages_sent < BURST_TO);
            if (s_tvalid && s_tready) begin
                nxt_valid = 1'b0;
                pages_sent <= pages_sent + 1;
            end
            if (cfg_valid && cfg_ready) nxt_cfg_valid = 1'b0;
            // frame count only changes once the block has drained
            if (!s_tvalid && !cfg_valid && pages_sent == results_seen) quiet++;
            else quiet = 0;
            if (!nxt_valid && !nxt_cfg_valid && pending_reqs.size() > 0) begin
                if (pending_reqs[0].kind == REQ_CFG) begin
                    if (quiet >= CFG_SETTLE) begin
                        req = pending_reqs.pop_front();
                        nxt_cfg_valid = 1'b1;
                        nxt_cfg_data  = req.frames;
                        quiet = 0;
                    end
                end else if (burst || $urandom_range(0, 99) >= GAP_PCT) begin
                    req = pending_reqs.pop_front();
                    nxt_valid = 1'b1;
                    nxt_page  = req.page;
                    nxt_last  = req.last;
                end
            end
            s_tvalid  <= nxt_valid;
            s_tdata   <= nxt_page;
            s_tlast   <= nxt_last;
            cfg_valid <= nxt_cfg_valid;
            cfg_data  <= nxt_cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: random back-pressure plus one long hold-off
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : drive_ready
        int unsigned hold_left;
        logic        hold_done;
        if (!aresetn) begin
            m_tready <= 1'b0;
            hold_left = 0;
            hold_done = 1'b0;
        end else begin
            if (!hold_done && results_seen >= HOLD_AT) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (results_seen >= BURST_FROM && results_seen < BURST_TO) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= GAP_PCT);
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks results, then tracks accepted requests
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : check_results
        lru_result_t want;
        lru_result_t got;
        if (!aresetn) begin
            lru_occ    = 0;
            lru_faults = '0;
            lru_frames = FRAME_COUNT_RESET;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen <= results_seen + 1;
                got.hit      = m_tuser[0];
                got.ev_valid = m_tuser[1];
                got.ev_page  = m_tdata[PAGE_BITS-1:0];
                got.faults   = m_tdata[PAGE_BITS +: FAULT_W];
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("result %0d with no request outstanding: %s",
                                 results_seen,
                                 $sformatf("hit=%0b ev=%0b/%h faults=%0d",
                                           got.hit, got.ev_valid, got.ev_page,
                                           got.faults));
                end else begin
                    want = expected_results.pop_front();
                    if (got.hit !== want.hit || got.ev_valid !== want.ev_valid ||
                        got.ev_page !== want.ev_page || got.faults !== want.faults) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $write("result %0d: expected hit=%0b ev=%0b/%h faults=%0d, ",
                                   results_seen, want.hit, want.ev_valid, want.ev_page,
                                   want.faults);
                            $display("got hit=%0b ev=%0b/%h faults=%0d",
                                     got.hit, got.ev_valid, got.ev_page, got.faults);
                        end
                    end
                end
            end
            if (cfg_valid && cfg_ready) lru_frames = cfg_data;
            if (s_tvalid && s_tready) expected_results.push_back(lru_reference(s_tdata, s_tlast));
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic add_page(input logic [PAGE_BITS-1:0] page, input logic last);
        stim_req_t r;
        r.kind   = REQ_PAGE;
        r.page   = page;
        r.last   = last;
        r.frames = '0;
        pending_reqs.push_back(r);
        stim_items++;
    endtask

    task automatic add_cfg(input logic [CFG_W-1:0] frames);
        stim_req_t r;
        r.kind   = REQ_CFG;
        r.page   = '0;
        r.last   = 1'b0;
        r.frames = frames;
        pending_reqs.push_back(r);
    endtask

    function automatic logic [CFG_W-1:0] phase_frames(input int unsigned phase);
        case (phase)
            0:  return 6'd32;
            1:  return 6'd63;
            2:  return 6'd1;
            3:  return 6'd0;
            4:  return 6'd2;
            5:  return 6'd16;
            6:  return 6'd33;
            7:  return 6'd5;
            8:  return 6'd31;
            9:  return 6'd3;
            10: return 6'd8;
            default: return CFG_W'($urandom_range(0, 63));
        endcase
    endfunction

    initial begin : stimulus
        int unsigned          phase;
        int unsigned          cap;
        int unsigned          left;
        int unsigned          run_len;
        int unsigned          pool;
        logic [PAGE_BITS-1:0] base;
        logic [PAGE_BITS-1:0] page;
        logic                 last;
        logic [CFG_W-1:0]     frames;

        // reset frame count of four: cold fills, a hit, an LRU eviction
        add_page(16'h0000, 1'b0);
        add_page(16'hFFFF, 1'b0);
        add_page(16'h0001, 1'b0);
        add_page(16'h0002, 1'b0);
        add_page(16'h0000, 1'b0);
        add_page(16'h0003, 1'b0);
        add_page(16'hAAAA, 1'b0);
        add_page(16'h5555, 1'b1);
        // frame count zero behaves as a single frame
        add_cfg(6'd0);
        add_page(16'h0007, 1'b0);
        add_page(16'h0007, 1'b0);
        add_page(16'h0008, 1'b0);
        add_page(16'h0008, 1'b1);
        // lower the frame count with pages resident
        add_cfg(6'd3);
        add_page(16'h0010, 1'b0);
        add_page(16'h0011, 1'b0);
        add_page(16'h0012, 1'b0);
        add_cfg(6'd1);
        add_page(16'h0013, 1'b0);
        add_page(16'h0012, 1'b0);
        add_page(16'h0011, 1'b0);
        add_page(16'h0014, 1'b1);

        phase = 0;
        while (stim_items < ITEM_TARGET) begin
            frames = phase_frames(phase);
            add_cfg(frames);
            cap  = frames_in_use(frames);
            left = $urandom_range(40, 80);
            while (left > 0) begin
                run_len = $urandom_range(1, 2 * cap + 20);
                if (run_len > left) run_len = left;
                pool = $urandom_range(1, cap + cap / 2 + 2);
                base = PAGE_BITS'($urandom_range(0, 65535));
                for (int unsigned k = 0; k < run_len; k++) begin
                    if ($urandom_range(0, 99) < 8) page = PAGE_BITS'($urandom_range(0, 65535));
                    else page = base + PAGE_BITS'($urandom_range(0, pool - 1));
                    if (k == run_len - 1)
                        // sometimes carry the store over into the next frame count
                        last = !(run_len == left && $urandom_range(0, 99) < 30);
                    else
                        last = ($urandom_range(0, 99) < 3);
                    add_page(page, last);
                end
                left -= run_len;
            end
            phase++;
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_reqs.size() != 0 || s_tvalid || cfg_valid || pages_sent != results_seen)
            @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
